/* hdl/script_image_loader_and_fetch_top_assert.svh */
// Assertion macros used by the loader's back part.
`ifndef SCRIPT_IMAGE_LOADER_AND_FETCH_TOP_ASSERT_SVH
`define SCRIPT_IMAGE_LOADER_AND_FETCH_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SILF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define SILF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/silf_pkg.sv */
// ----------------------------------------------------------------------------
// silf_pkg
// Types and constants shared by the script image loader modules.
// ----------------------------------------------------------------------------
package silf_pkg;

  localparam int unsigned StoreDepth = 512;
  localparam int unsigned SlotW = $clog2(StoreDepth);
  localparam int unsigned CountW = $clog2(StoreDepth + 1);
  localparam int unsigned SlotOutW = 9;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueW = $clog2(QueueDepth);

  localparam logic [5:0] PreambleEnd = 6'd32;
  localparam logic [5:0] CountFirst = 6'd24;
  localparam logic [3:0] FrameLast = 4'd15;

  typedef enum logic [2:0] {
    RK_HEADER = 3'd0,
    RK_STORED = 3'd1,
    RK_HIT    = 3'd2,
    RK_MISS   = 3'd3,
    RK_DROP   = 3'd4
  } result_kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [63:0] entry_key;
    logic [63:0] entry_value;
    logic [31:0] record_address;
    logic [15:0] operation_code;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [15:0] debug_tag;
    logic [8:0]  slot;
    logic [31:0] fetch_counter;
  } out_item_t;

  // Command from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_EMIT  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_FETCH = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    out_item_t   item;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_WAIT = 2'd2,
    BK_OUT  = 2'd3
  } back_state_t;

endpackage

/* hdl/silf_front.sv */
// ----------------------------------------------------------------------------
// silf_front
// Parses image bytes and turns items into commands for the back part.
// ----------------------------------------------------------------------------
module silf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  silf_pkg::in_item_t in_item,
  output logic               cmd_valid,
  output silf_pkg::cmd_t     cmd,
  input  logic               cmd_full
);

  logic [5:0]  byte_position;
  logic [63:0] entry_total;
  logic [63:0] entry_number;
  logic [3:0]  entry_byte_pos;
  logic [63:0] entry_w0, entry_w1;
  logic [3:0]  record_byte_pos;
  logic [63:0] rec_w0, rec_w1;
  logic [31:0] fetch_pc;
  logic        take;
  logic        in_pre, in_hdr;
  logic [63:0] w1_new;

  assign full = cmd_full;
  assign take = push && !cmd_full;
  assign in_pre = byte_position < silf_pkg::PreambleEnd;
  assign in_hdr = entry_number < entry_total;
  assign w1_new = {rec_w1[55:0], in_item.data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      entry_total <= '0;
      entry_number <= '0;
      entry_byte_pos <= '0;
      entry_w0 <= '0;
      entry_w1 <= '0;
      record_byte_pos <= '0;
      rec_w0 <= '0;
      rec_w1 <= '0;
      fetch_pc <= '0;
    end else if (take) begin
      if (in_item.kind) begin
        fetch_pc <= fetch_pc + 32'd1;
      end else if (in_pre) begin
        if (byte_position >= silf_pkg::CountFirst) begin
          entry_total <= {entry_total[55:0], in_item.data_byte};
        end
        byte_position <= byte_position + 6'd1;
      end else if (in_hdr) begin
        if (!entry_byte_pos[3]) begin
          entry_w0 <= {entry_w0[55:0], in_item.data_byte};
        end else begin
          entry_w1 <= {entry_w1[55:0], in_item.data_byte};
        end
        entry_byte_pos <= entry_byte_pos + 4'd1;
        if (entry_byte_pos == silf_pkg::FrameLast) begin
          entry_number <= entry_number + 64'd1;
        end
      end else begin
        if (!record_byte_pos[3]) begin
          rec_w0 <= {rec_w0[55:0], in_item.data_byte};
        end else begin
          rec_w1 <= w1_new;
        end
        record_byte_pos <= record_byte_pos + 4'd1;
      end
    end
  end

  always_comb begin
    cmd = '0;
    cmd_valid = 1'b0;
    if (take) begin
      if (in_item.kind) begin
        cmd_valid = 1'b1;
        cmd.op = silf_pkg::CMD_FETCH;
        cmd.item.fetch_counter = fetch_pc;
      end else if (!in_pre && in_hdr) begin
        if (entry_byte_pos == silf_pkg::FrameLast) begin
          cmd_valid = 1'b1;
          cmd.op = silf_pkg::CMD_EMIT;
          cmd.item.result_kind = silf_pkg::RK_HEADER;
          cmd.item.entry_key = entry_w0;
          cmd.item.entry_value = {entry_w1[55:0], in_item.data_byte};
        end
      end else if (!in_pre && record_byte_pos == silf_pkg::FrameLast) begin
        cmd_valid = 1'b1;
        cmd.op = silf_pkg::CMD_STORE;
        cmd.item.record_address = rec_w0[63:32];
        cmd.item.operation_code = rec_w0[31:16];
        cmd.item.operand_a = {rec_w0[15:0], w1_new[63:48]};
        cmd.item.operand_b = w1_new[47:16];
        cmd.item.debug_tag = w1_new[15:0];
      end
    end
  end

endmodule

/* hdl/silf_queue.sv */
// ----------------------------------------------------------------------------
// silf_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module silf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  silf_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd,
  output logic           empty,
  output silf_pkg::cmd_t rd_data
);

  silf_pkg::cmd_t entries [silf_pkg::QueueDepth];
  logic [silf_pkg::QueueW-1:0] wp, rp;
  logic [silf_pkg::QueueW:0]   count;

  assign full = count == (silf_pkg::QueueW+1)'(silf_pkg::QueueDepth);
  assign empty = count == '0;
  assign rd_data = entries[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      count <= count + (silf_pkg::QueueW+1)'(wr) - (silf_pkg::QueueW+1)'(rd);
    end
  end

endmodule

/* hdl/silf_back.sv */
// ----------------------------------------------------------------------------
// silf_back
// Stores records, scans the store for fetches and holds the result register.
// ----------------------------------------------------------------------------
`include "script_image_loader_and_fetch_top_assert.svh"

module silf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  silf_pkg::cmd_t      q_data,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output silf_pkg::out_item_t out_item
);

  logic [31:0] address_store [silf_pkg::StoreDepth];
  logic [63:0] body_store    [silf_pkg::StoreDepth];
  logic [15:0] opcode_store  [silf_pkg::StoreDepth];
  logic [15:0] tag_store     [silf_pkg::StoreDepth];

  silf_pkg::back_state_t state, state_next;
  logic [silf_pkg::CountW-1:0] record_count;
  logic [silf_pkg::CountW-1:0] scan_idx;
  logic [31:0] rd_addr;
  logic [63:0] rd_body;
  logic [15:0] rd_op, rd_tag;
  logic        rd_live;
  logic [silf_pkg::CountW-1:0] rd_idx;
  silf_pkg::out_item_t result, result_next;
  logic        store_we, scan_en, load_cmd, hit, scan_end, res_hit, res_miss;

  always_ff @(posedge clk) begin
    if (store_we) begin
      address_store[record_count[silf_pkg::SlotW-1:0]] <= q_data.item.record_address;
      body_store[record_count[silf_pkg::SlotW-1:0]] <=
        {q_data.item.operand_a, q_data.item.operand_b};
      opcode_store[record_count[silf_pkg::SlotW-1:0]] <= q_data.item.operation_code;
      tag_store[record_count[silf_pkg::SlotW-1:0]] <= q_data.item.debug_tag;
    end
    if (scan_en) begin
      rd_addr <= address_store[scan_idx[silf_pkg::SlotW-1:0]];
      rd_body <= body_store[scan_idx[silf_pkg::SlotW-1:0]];
      rd_op <= opcode_store[scan_idx[silf_pkg::SlotW-1:0]];
      rd_tag <= tag_store[scan_idx[silf_pkg::SlotW-1:0]];
      rd_idx <= scan_idx;
    end
  end

  assign hit = rd_live && rd_addr == result.fetch_counter;
  assign scan_end = scan_idx >= record_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= silf_pkg::BK_IDLE;
      record_count <= '0;
      scan_idx <= '0;
      rd_live <= 1'b0;
    end else begin
      state <= state_next;
      if (store_we) begin
        record_count <= record_count + 1'b1;
      end
      if (load_cmd) begin
        scan_idx <= '0;
      end else if (scan_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      rd_live <= scan_en;
    end
  end

  always_comb begin
    result_next = result;
    if (load_cmd) begin
      result_next = q_data.item;
      if (q_data.op == silf_pkg::CMD_STORE) begin
        if (store_we) begin
          result_next.result_kind = silf_pkg::RK_STORED;
          result_next.slot = silf_pkg::SlotOutW'(record_count);
        end else begin
          result_next.result_kind = silf_pkg::RK_DROP;
        end
      end
    end else if (res_hit) begin
      result_next.result_kind = silf_pkg::RK_HIT;
      result_next.record_address = rd_addr;
      result_next.operation_code = rd_op;
      result_next.operand_a = rd_body[63:32];
      result_next.operand_b = rd_body[31:0];
      result_next.debug_tag = rd_tag;
      result_next.slot = silf_pkg::SlotOutW'(rd_idx);
    end else if (res_miss) begin
      result_next.result_kind = silf_pkg::RK_MISS;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_comb begin
    state_next = state;
    q_rd = 1'b0;
    load_cmd = 1'b0;
    store_we = 1'b0;
    scan_en = 1'b0;
    res_hit = 1'b0;
    res_miss = 1'b0;
    empty = 1'b1;
    case (state)
      silf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          load_cmd = 1'b1;
          if (q_data.op == silf_pkg::CMD_FETCH) begin
            state_next = silf_pkg::BK_SCAN;
          end else begin
            store_we = q_data.op == silf_pkg::CMD_STORE &&
                       record_count < silf_pkg::CountW'(silf_pkg::StoreDepth);
            state_next = silf_pkg::BK_OUT;
          end
        end
      end
      silf_pkg::BK_SCAN: begin
        if (hit) begin
          res_hit = 1'b1;
          state_next = silf_pkg::BK_OUT;
        end else if (scan_end) begin
          state_next = silf_pkg::BK_WAIT;
        end else begin
          scan_en = 1'b1;
        end
      end
      silf_pkg::BK_WAIT: begin
        if (hit) begin
          res_hit = 1'b1;
        end else begin
          res_miss = 1'b1;
        end
        state_next = silf_pkg::BK_OUT;
      end
      silf_pkg::BK_OUT: begin
        empty = 1'b0;
        if (pop) begin
          state_next = silf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = silf_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_item = result;

  `SILF_ASSERT_IMP(a_count_max, clk, rst, 1'b1,
    record_count <= silf_pkg::CountW'(silf_pkg::StoreDepth), "record count overflow")
  `SILF_ASSERT_NXT(a_store_grows, clk, rst, store_we,
    record_count == $past(record_count) + 1'b1, "store write lost")
  `SILF_ASSERT_IMP(a_scan_bound, clk, rst, scan_en,
    scan_idx < record_count, "scan past filled slots")
  `SILF_ASSERT_IMP(a_no_read_out, clk, rst, q_rd,
    state == silf_pkg::BK_IDLE, "queue read while busy")

endmodule

/* hdl/script_image_loader_and_fetch_top.sv */
// ----------------------------------------------------------------------------
// script_image_loader_and_fetch_top
// Script image loader with address-matched instruction fetch.
// ----------------------------------------------------------------------------
// Usage: items enter on a queue-like port (push/full). Each item is either
// one image byte or a fetch tick. Results leave on a queue-like port
// (empty/pop); the oldest result is on the out port while empty is low.
// A front part parses the image and keeps the program counter; it passes
// commands through a four-entry queue to a back part that owns the record
// store (one read port, one write port) and the result register.
// With the back part idle, a header entry or a stored record passes through
// the queue and then the result register before it is on the result port. A
// tick scans the stored records one slot per cycle through the store's
// single read port and stops at the first slot whose address equals the
// program counter; that hit, or a miss once the filled slots are done, then
// goes to the result register. Bytes that give no result are accepted back
// to back while the queue has room; the back part takes no new command
// until its result has been popped.
// Reset clears the parser, counter and queue; the store needs no clearing
// because only filled slots are read. When the receiver stalls the result
// waits in its register, the queue fills, and full then rises.
// ----------------------------------------------------------------------------
module script_image_loader_and_fetch_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  silf_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output silf_pkg::out_item_t out_item
);

  logic           cmd_valid;
  silf_pkg::cmd_t cmd;
  logic           q_full, q_empty, q_rd;
  silf_pkg::cmd_t q_data;

  // The front stalls only when the command queue is full.
  silf_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_full(q_full)
  );

  silf_queue u_queue (
    .clk(clk), .rst(rst), .wr(cmd_valid), .wr_data(cmd), .full(q_full),
    .rd(q_rd), .empty(q_empty), .rd_data(q_data)
  );

  // The back part turns each command into exactly one result transfer.
  silf_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_data), .q_rd(q_rd),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

endmodule
